// ----- rtl/cswt_pkg.sv -----
// Package for the centroid smoother and zone trigger.
// Types and constants shared by the register block, update logic and top level.
package cswt_pkg;

  localparam int unsigned PixW   = 12;
  localparam int unsigned CoordW = 21;
  localparam int unsigned WeightW = 9;
  localparam int unsigned FracW  = 8;
  localparam int unsigned AccW   = 30;
  localparam int unsigned AddrW  = 4;

  localparam logic [WeightW-1:0] WeightMin   = 9'd3;
  localparam logic [WeightW-1:0] WeightOne   = 9'd256;
  localparam logic [WeightW-1:0] WeightReset = 9'd77;
  localparam logic [PixW-1:0]    TopReset    = 12'd0;
  localparam logic [PixW-1:0]    BottomReset = 12'd4095;
  localparam logic [AccW-1:0]    RoundHalf   = 30'd128;

  typedef enum logic [1:0] {
    REG_WEIGHT   = 2'd0,
    REG_WIN_TOP  = 2'd1,
    REG_WIN_BOT  = 2'd2,
    REG_ON_ENTRY = 2'd3
  } reg_idx_t;

  typedef enum logic {
    FUNC_FRAME   = 1'b0,
    FUNC_CONSUME = 1'b1
  } func_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [PixW-1:0]    win_top;
    logic [PixW-1:0]    win_bottom;
    logic               on_entry;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic              person_present;
    logic [PixW-1:0]   box_left;
    logic [PixW-1:0]   box_top;
    logic [PixW-1:0]   box_width;
    logic [PixW-1:0]   box_height;
  } item_t;

  typedef struct packed {
    logic [CoordW-1:0] avg_x;
    logic [CoordW-1:0] avg_y;
    logic              avg_valid;
    logic              was_in_window;
    logic              trigger_pending;
  } track_t;

  typedef struct packed {
    logic              smoothed_valid;
    logic [CoordW-1:0] smoothed_x;
    logic [CoordW-1:0] smoothed_y;
    logic              in_window;
    logic              trigger;
  } result_t;

endpackage

// ----- rtl/cswt_regs.sv -----
// APB-style configuration registers for the centroid smoother.
// Depends on cswt_pkg.
module cswt_regs (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [cswt_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output cswt_pkg::cfg_t            cfg
);
  import cswt_pkg::*;

  cfg_t     cfg_next;
  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    cfg_next = cfg;
    if (wr) begin
      unique case (idx)
        REG_WEIGHT:   cfg_next.weight     = pwdata[WeightW-1:0];
        REG_WIN_TOP:  cfg_next.win_top    = pwdata[PixW-1:0];
        REG_WIN_BOT:  cfg_next.win_bottom = pwdata[PixW-1:0];
        REG_ON_ENTRY: cfg_next.on_entry   = pwdata[0];
        default:      cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight     <= WeightReset;
      cfg.win_top    <= TopReset;
      cfg.win_bottom <= BottomReset;
      cfg.on_entry   <= 1'b1;
    end else begin
      cfg <= cfg_next;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_WEIGHT:   prdata = {{(32-WeightW){1'b0}}, cfg.weight};
      REG_WIN_TOP:  prdata = {{(32-PixW){1'b0}}, cfg.win_top};
      REG_WIN_BOT:  prdata = {{(32-PixW){1'b0}}, cfg.win_bottom};
      REG_ON_ENTRY: prdata = {31'd0, cfg.on_entry};
      default:      prdata = '0;
    endcase
  end

endmodule

// ----- rtl/cswt_update.sv -----
// Per-item update: box centre, EMA smoothing, window test and trigger latch.
// Purely combinational; depends on cswt_pkg.
module cswt_update (
  input  cswt_pkg::cfg_t    cfg,
  input  cswt_pkg::item_t   item,
  input  cswt_pkg::track_t  cur,
  output cswt_pkg::track_t  nxt,
  output cswt_pkg::result_t res
);
  import cswt_pkg::*;

  logic [WeightW-1:0] w;
  logic [WeightW-1:0] w_inv;
  logic [CoordW-1:0]  cx;
  logic [CoordW-1:0]  cy;
  logic [AccW-1:0]    acc_x;
  logic [AccW-1:0]    acc_y;
  logic [CoordW-1:0]  ema_x;
  logic [CoordW-1:0]  ema_y;
  logic [CoordW-1:0]  lo_bound;
  logic [CoordW-1:0]  hi_bound;
  logic               in_zone;

  always_comb begin
    priority if (cfg.weight < WeightMin) w = WeightMin;
    else if (cfg.weight > WeightOne)     w = WeightOne;
    else                                 w = cfg.weight;
  end

  assign w_inv = WeightOne - w;

  assign cx = {1'b0, item.box_left, 8'd0} + {2'b00, item.box_width, 7'd0};
  assign cy = {1'b0, item.box_top,  8'd0} + {2'b00, item.box_height, 7'd0};

  assign acc_x = AccW'(w * cx) + AccW'(w_inv * cur.avg_x) + RoundHalf;
  assign acc_y = AccW'(w * cy) + AccW'(w_inv * cur.avg_y) + RoundHalf;
  assign ema_x = acc_x[FracW +: CoordW];
  assign ema_y = acc_y[FracW +: CoordW];

  assign lo_bound = {1'b0, cfg.win_top, 8'd0};
  assign hi_bound = {1'b0, cfg.win_bottom, 8'd0};

  always_comb begin
    nxt     = cur;
    in_zone = 1'b0;
    if (item.func == FUNC_CONSUME) begin
      nxt.trigger_pending = 1'b0;
    end else if (item.person_present) begin
      nxt.avg_x     = cur.avg_valid ? ema_x : cx;
      nxt.avg_y     = cur.avg_valid ? ema_y : cy;
      nxt.avg_valid = 1'b1;
      in_zone = (nxt.avg_y >= lo_bound) && (nxt.avg_y <= hi_bound);
      if (cfg.on_entry && !cur.was_in_window && in_zone)
        nxt.trigger_pending = 1'b1;
      else if (!cfg.on_entry && cur.was_in_window && !in_zone)
        nxt.trigger_pending = 1'b1;
      nxt.was_in_window = in_zone;
    end else begin
      nxt.avg_x         = '0;
      nxt.avg_y         = '0;
      nxt.avg_valid     = 1'b0;
      nxt.was_in_window = 1'b0;
    end
  end

  always_comb begin
    res.smoothed_valid = nxt.avg_valid;
    res.smoothed_x     = nxt.avg_x;
    res.smoothed_y     = nxt.avg_y;
    res.in_window      = nxt.was_in_window;
    res.trigger        = (item.func == FUNC_CONSUME) ? cur.trigger_pending
                                                     : nxt.trigger_pending;
  end

endmodule

// ----- rtl/centroid_smoother_zone_trigger.sv -----
// Centroid smoother with zone trigger: top level.
// Input register, update logic, tracking state and result register.
// Depends on cswt_pkg, cswt_regs and cswt_update.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: a frame update
//   (func = 0) with an optional box, or a consume request (func = 1).
//   Output channel (out_valid / out_stall) returns exactly one result item
//   per input item, in order.
//   The result passes through two register stages from the input ports:
//   the input register, then the result register. Throughput is one
//   item per cycle while out_stall is low; the tracking state updates
//   as an item moves from the input register into the result register.
//   While the receiver stalls, the result register holds; one more item
//   waits in the input register, then in_stall rises.
//   Synchronous reset clears the tracking state and both valid flags and
//   loads the configuration defaults. Configuration is written over the
//   APB-style port only while idle, a user rule the block does not enforce.
module centroid_smoother_zone_trigger (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cswt_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         func,
  input  logic                         person_present,
  input  logic [cswt_pkg::PixW-1:0]    box_left,
  input  logic [cswt_pkg::PixW-1:0]    box_top,
  input  logic [cswt_pkg::PixW-1:0]    box_width,
  input  logic [cswt_pkg::PixW-1:0]    box_height,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         smoothed_valid,
  output logic [cswt_pkg::CoordW-1:0]  smoothed_x,
  output logic [cswt_pkg::CoordW-1:0]  smoothed_y,
  output logic                         in_window,
  output logic                         trigger
);
  import cswt_pkg::*;

  cfg_t    cfg;
  item_t   inq;
  logic    inq_valid;
  track_t  track;
  track_t  track_next;
  result_t res_next;
  result_t res;
  logic    advance;
  logic    out_valid_next;

  cswt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cswt_update u_update (
    .cfg  (cfg),
    .item (inq),
    .cur  (track),
    .nxt  (track_next),
    .res  (res_next)
  );

  assign advance  = inq_valid && !(out_valid && out_stall);
  assign in_stall = inq_valid && out_valid && out_stall;

  always_comb begin
    if (advance)        out_valid_next = 1'b1;
    else if (out_stall) out_valid_next = out_valid;
    else                out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      out_valid <= 1'b0;
      track     <= '0;
    end else begin
      if (!in_stall) inq_valid <= in_valid;
      out_valid <= out_valid_next;
      if (advance) track <= track_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      inq.func           <= func;
      inq.person_present <= person_present;
      inq.box_left       <= box_left;
      inq.box_top        <= box_top;
      inq.box_width      <= box_width;
      inq.box_height     <= box_height;
    end
    if (advance) res <= res_next;
  end

  assign smoothed_valid = res.smoothed_valid;
  assign smoothed_x     = res.smoothed_x;
  assign smoothed_y     = res.smoothed_y;
  assign in_window      = res.in_window;
  assign trigger        = res.trigger;

endmodule

// ----- rtl/cswt_checker.sv -----
// Port-level checks for the centroid smoother, bound to the top level.
// Depends on cswt_pkg for field widths.
module cswt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        smoothed_valid,
  input logic [cswt_pkg::CoordW-1:0] smoothed_x,
  input logic [cswt_pkg::CoordW-1:0] smoothed_y,
  input logic                        in_window,
  input logic                        trigger
);
  import cswt_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(smoothed_x) && $stable(smoothed_y)
      && $stable(trigger))
    else $error("result changed while stalled");

  a_empty_avg: assert property (@(posedge clk) disable iff (rst)
    out_valid && !smoothed_valid |-> smoothed_x == '0 && smoothed_y == '0
      && !in_window)
    else $error("average not cleared without detection");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with output free");

endmodule

bind centroid_smoother_zone_trigger cswt_checker u_cswt_checker (.*);

// ----- tb/tb_centroid_smoother_zone_trigger.sv -----
// Testbench for centroid_smoother_zone_trigger: directed and random frame/consume items,
// checked item by item against an in-bench EMA and window-trigger predictor.
// Depends on cswt_pkg and the centroid_smoother_zone_trigger RTL.
module tb_centroid_smoother_zone_trigger;
  import cswt_pkg::*;

  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned MaxReports = 10;

  class centroid_scoreboard;
    cfg_t        cfg;
    track_t      trk;
    result_t     expected_q[$];
    int unsigned mismatches;

    function new();
      reset_state();
      mismatches = 0;
    endfunction

    function void reset_state();
      cfg.weight     = WeightReset;
      cfg.win_top    = TopReset;
      cfg.win_bottom = BottomReset;
      cfg.on_entry   = 1'b1;
      trk            = '0;
      expected_q.delete();
    endfunction

    function void write_reg(reg_idx_t idx, logic [31:0] value);
      case (idx)
        REG_WEIGHT:   cfg.weight     = value[WeightW-1:0];
        REG_WIN_TOP:  cfg.win_top    = value[PixW-1:0];
        REG_WIN_BOT:  cfg.win_bottom = value[PixW-1:0];
        REG_ON_ENTRY: cfg.on_entry   = value[0];
        default: ;
      endcase
    endfunction

    function logic [CoordW-1:0] blend(logic [WeightW-1:0] w, logic [CoordW-1:0] sample,
                                      logic [CoordW-1:0] prev);
      logic [63:0] w64;
      logic [63:0] rest64;
      logic [63:0] acc;
      w64    = 64'(w);
      rest64 = 64'(WeightOne) - w64;
      acc    = w64 * 64'(sample) + rest64 * 64'(prev) + 64'(RoundHalf);
      return acc[CoordW+FracW-1:FracW];
    endfunction

    function void note_item(item_t it);
      logic [CoordW-1:0]  cx;
      logic [CoordW-1:0]  cy;
      logic [WeightW-1:0] w;
      logic               in_zone;
      result_t            r;
      logic               fired;
      if (it.func == FUNC_CONSUME) begin
        fired = trk.trigger_pending;
        trk.trigger_pending = 1'b0;
      end else if (it.person_present) begin
        cx = (CoordW'(it.box_left) << FracW) + (CoordW'(it.box_width) << (FracW - 1));
        cy = (CoordW'(it.box_top) << FracW) + (CoordW'(it.box_height) << (FracW - 1));
        w = cfg.weight;
        if (w < WeightMin) w = WeightMin;
        else if (w > WeightOne) w = WeightOne;
        if (trk.avg_valid) begin
          trk.avg_x = blend(w, cx, trk.avg_x);
          trk.avg_y = blend(w, cy, trk.avg_y);
        end else begin
          trk.avg_x = cx;
          trk.avg_y = cy;
        end
        trk.avg_valid = 1'b1;
        in_zone = (trk.avg_y >= (CoordW'(cfg.win_top) << FracW)) &&
                  (trk.avg_y <= (CoordW'(cfg.win_bottom) << FracW));
        if (cfg.on_entry && !trk.was_in_window && in_zone) trk.trigger_pending = 1'b1;
        else if (!cfg.on_entry && trk.was_in_window && !in_zone) trk.trigger_pending = 1'b1;
        trk.was_in_window = in_zone;
        fired = trk.trigger_pending;
      end else begin
        trk.avg_x = '0;
        trk.avg_y = '0;
        trk.avg_valid = 1'b0;
        trk.was_in_window = 1'b0;
        fired = trk.trigger_pending;
      end
      r.smoothed_valid = trk.avg_valid;
      r.smoothed_x     = trk.avg_x;
      r.smoothed_y     = trk.avg_y;
      r.in_window      = trk.was_in_window;
      r.trigger        = fired;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: v=%0d x=%0d y=%0d win=%0d trig=%0d",
                   got.smoothed_valid, got.smoothed_x, got.smoothed_y, got.in_window,
                   got.trigger);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.smoothed_valid !== exp_r.smoothed_valid || got.smoothed_x !== exp_r.smoothed_x ||
          got.smoothed_y !== exp_r.smoothed_y || got.in_window !== exp_r.in_window ||
          got.trigger !== exp_r.trigger) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display({"mismatch: exp v=%0d x=%0d y=%0d win=%0d trig=%0d",
                    " | got v=%0d x=%0d y=%0d win=%0d trig=%0d"},
                   exp_r.smoothed_valid, exp_r.smoothed_x, exp_r.smoothed_y, exp_r.in_window,
                   exp_r.trigger, got.smoothed_valid, got.smoothed_x, got.smoothed_y,
                   got.in_window, got.trigger);
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               func = 1'b0;
  logic               person_present = 1'b0;
  logic [PixW-1:0]    box_left = '0;
  logic [PixW-1:0]    box_top = '0;
  logic [PixW-1:0]    box_width = '0;
  logic [PixW-1:0]    box_height = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               smoothed_valid;
  logic [CoordW-1:0]  smoothed_x;
  logic [CoordW-1:0]  smoothed_y;
  logic               in_window;
  logic               trigger;

  centroid_scoreboard sb = new();
  bit                 hold_req = 1'b0;
  int unsigned        cycle_count = 0;
  int unsigned        burst_left = 0;
  result_t            seen;

  centroid_smoother_zone_trigger u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .person_present (person_present),
    .box_left       (box_left),
    .box_top        (box_top),
    .box_width      (box_width),
    .box_height     (box_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .smoothed_valid (smoothed_valid),
    .smoothed_x     (smoothed_x),
    .smoothed_y     (smoothed_y),
    .in_window      (in_window),
    .trigger        (trigger)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen.smoothed_valid = smoothed_valid;
      seen.smoothed_x     = smoothed_x;
      seen.smoothed_y     = smoothed_y;
      seen.in_window      = in_window;
      seen.trigger        = trigger;
      sb.check_result(seen);
    end
  end

  // result-side back-pressure: random modes, with an occasional long hold-off
  initial begin
    int unsigned mode;
    int unsigned span;
    logic [31:0] pattern;
    mode = 0;
    span = 0;
    pattern = '0;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          mode    = $urandom_range(0, 3);
          span    = $urandom_range(8, 64);
          pattern = $urandom;
        end
        span--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= pattern[span % 32];
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(item_t it);
    in_valid       <= 1'b1;
    func           <= it.func;
    person_present <= it.person_present;
    box_left       <= it.box_left;
    box_top        <= it.box_top;
    box_width      <= it.box_width;
    box_height     <= it.box_height;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic pause_input(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic item_t mk(func_t f, logic p, logic [PixW-1:0] l, logic [PixW-1:0] t,
                               logic [PixW-1:0] w, logic [PixW-1:0] h);
    item_t it;
    it.func           = f;
    it.person_present = p;
    it.box_left       = l;
    it.box_top        = t;
    it.box_width      = w;
    it.box_height     = h;
    return it;
  endfunction

  // mostly detections near a window bound, so the centroid crosses it often
  function automatic item_t random_item();
    item_t       it;
    int unsigned r;
    int          y;
    r = $urandom_range(0, 99);
    it = mk(FUNC_FRAME, 1'b1, PixW'($urandom), PixW'($urandom), PixW'($urandom),
            PixW'($urandom));
    if (r < 10) begin
      it.func = FUNC_CONSUME;
      it.person_present = 1'($urandom_range(0, 1));
    end else if (r < 18) begin
      it.person_present = 1'b0;
    end else if (r >= 25) begin
      y = ($urandom_range(0, 1) ? int'(sb.cfg.win_top) : int'(sb.cfg.win_bottom)) +
          int'($urandom_range(0, 160)) - 80;
      if (y < 0) y = 0;
      if (y > 4095) y = 4095;
      it.box_top    = PixW'(y);
      it.box_height = ($urandom_range(0, 3) == 0) ? '0 : PixW'($urandom_range(0, 63));
    end
    return it;
  endfunction

  task automatic run_phase(logic [WeightW-1:0] w, logic [PixW-1:0] top, logic [PixW-1:0] bot,
                           logic on_entry, int unsigned n, bit hold);
    int unsigned gap;
    write_reg(REG_WEIGHT, 32'(w));
    write_reg(REG_WIN_TOP, 32'(top));
    write_reg(REG_WIN_BOT, 32'(bot));
    write_reg(REG_ON_ENTRY, 32'(on_entry));
    for (int unsigned i = 0; i < n; i++) begin
      if (hold && i == n / 2) begin
        hold_req = 1'b1;
        burst_left = 30;
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) pause_input(gap);
        burst_left = $urandom_range(1, 16);
      end
      send_item(random_item());
      burst_left--;
    end
    pause_input(1);
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(mk(FUNC_CONSUME, 1'b0, 0, 0, 0, 0));
    send_item(mk(FUNC_FRAME, 1'b0, 0, 0, 0, 0));
    send_item(mk(FUNC_FRAME, 1'b1, 0, 0, 0, 0));
    send_item(mk(FUNC_FRAME, 1'b1, 0, 0, 0, 0));
    send_item(mk(FUNC_CONSUME, 1'b0, 0, 0, 0, 0));
    send_item(mk(FUNC_CONSUME, 1'b0, 0, 0, 0, 0));
    repeat (4) send_item(mk(FUNC_FRAME, 1'b1, 4095, 4095, 4095, 4095));
    send_item(mk(FUNC_FRAME, 1'b0, 4095, 4095, 4095, 4095));
    send_item(mk(FUNC_FRAME, 1'b1, 4095, 4095, 4095, 4095));
    send_item(mk(FUNC_FRAME, 1'b1, 4095, 0, 0, 4095));
    send_item(mk(FUNC_FRAME, 1'b1, 0, 4095, 4095, 0));
    send_item(mk(FUNC_CONSUME, 1'b1, 4095, 4095, 4095, 4095));
    send_item(mk(FUNC_FRAME, 1'b0, 0, 0, 0, 0));
    send_item(mk(FUNC_FRAME, 1'b1, 0, 2048, 4095, 1));
    send_item(mk(FUNC_CONSUME, 1'b0, 0, 0, 0, 0));
    pause_input(1);
    drain();

    run_phase(256, 1000, 2000, 1'b1, 80, 1'b1);
    run_phase(0, 1000, 2000, 1'b0, 80, 1'b0);
    run_phase(511, 500, 500, 1'b1, 60, 1'b0);
    run_phase(3, 2500, 3000, 1'b0, 80, 1'b0);
    run_phase(128, 3000, 1000, 1'b1, 40, 1'b0);
    run_phase(255, 0, 0, 1'b0, 60, 1'b1);
    run_phase(257, 4095, 4095, 1'b1, 40, 1'b0);
    run_phase(1, 1500, 2600, 1'b0, 80, 1'b0);
    run_phase(2, 800, 3200, 1'b1, 40, 1'b0);
    run_phase(77, 0, 4095, 1'b1, 60, 1'b0);

    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/cswt_pkg.sv
rtl/cswt_regs.sv
rtl/cswt_update.sv
rtl/centroid_smoother_zone_trigger.sv
rtl/cswt_checker.sv
tb/tb_centroid_smoother_zone_trigger.sv
